// File: rtl/core/scp_pkg.sv
// Shared types and constants of the sprite column occlusion block.
// Depends on nothing; scp_div and the top level import it.
package scp_pkg;

  localparam int unsigned RAY_COLUMNS    = 256;
  localparam int unsigned MAX_HITS       = 4;
  localparam int unsigned SCREEN_COLUMNS = 1024;
  localparam int unsigned SCREEN_ROWS    = 512;

  localparam int unsigned RAY_AW  = $clog2(RAY_COLUMNS);
  localparam int unsigned HIT_AW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_HITS + 1);
  localparam int unsigned ENTRY_W = 24 + 24 + 8;

  localparam int unsigned DIVIDEND_W = 46;
  localparam int unsigned DIVISOR_W  = 24;
  localparam int unsigned QUOT_W     = 20;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [16:0] UNITY        = 17'd65536;
  localparam logic signed [25:0] LINE_INIT = 26'(SCREEN_ROWS * 256);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT,
    ST_HIT,
    ST_SCALE,
    ST_DIM,
    ST_SEG,
    ST_Y,
    ST_Y_WAIT,
    ST_H,
    ST_H_WAIT,
    ST_SEND
  } state_e;

endpackage

// File: rtl/core/scp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module scp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/scp_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 20 bits.
// Depends on scp_pkg.
module scp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [scp_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [scp_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [scp_pkg::QUOT_W-1:0]      quot_o
);
  import scp_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVIDEND_W-1:0] num_q, num_d;
  logic [DIVISOR_W-1:0]  den_q, den_d;
  logic [DIVISOR_W:0]    rem_q, rem_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q[DIVISOR_W-1:0], num_q[DIVIDEND_W-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIVIDEND_W);
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!diff[DIVISOR_W+1]) begin
        rem_d = diff[DIVISOR_W:0];
        num_d = {num_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[DIVIDEND_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = (|num_q[DIVIDEND_W-1:QUOT_W]) ? '1 : num_q[QUOT_W-1:0];

endmodule

// File: rtl/core/sprite_column_occlusion.sv
// Top level of the sprite column occlusion block: command decode, hit walk and segment build.
// Depends on scp_pkg, scp_ram and scp_div.
//
// A clear resets the valid flag of its ray column. A record reads the per-column count
// memory, then writes the hit and the count back. A query reads the count, then walks
// the stored hits of its ray column one per cycle, with an extra step for each nearer
// translucent hit to scale the dimming factor. Each emitted segment then runs up to two
// passes of the shared serial divider for its texture row and row count. Items are
// taken one at a time and a result beat is held until the sink takes it. Count entries
// are marked valid by flip-flops that reset clears, so no clearing pass is needed.
module sprite_column_occlusion (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // column, depth, top, alpha, height, brightness, color_r, color_g, color_b, tex_height
  input  logic [143:0] s_axis_tdata,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // seg_top, seg_bottom, src_y, src_h, out_r, out_g, out_b
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import scp_pkg::*;

  state_e state_q, state_d;

  logic [9:0]  in_column;
  logic [23:0] in_depth, in_top, in_height;
  logic [7:0]  in_alpha, in_r, in_g, in_b;
  logic [16:0] in_bright;
  logic [12:0] in_texh;
  logic [RAY_AW+9:0] ray_prod;
  logic [9:0]  ray_full;

  assign in_column = s_axis_tdata[9:0];
  assign in_depth  = s_axis_tdata[33:10];
  assign in_top    = s_axis_tdata[57:34];
  assign in_alpha  = s_axis_tdata[65:58];
  assign in_height = s_axis_tdata[89:66];
  assign in_bright = s_axis_tdata[106:90];
  assign in_r      = s_axis_tdata[114:107];
  assign in_g      = s_axis_tdata[122:115];
  assign in_b      = s_axis_tdata[130:123];
  assign in_texh   = s_axis_tdata[143:131];

  assign ray_prod = {{RAY_AW{1'b0}}, in_column} * (RAY_AW+10)'(RAY_COLUMNS);
  assign ray_full = 10'(ray_prod / SCREEN_COLUMNS);

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  cmd_e  cmd_q, cmd_d;
  logic  inrange_q, inrange_d;
  logic [RAY_AW-1:0] ray_q, ray_d;
  logic [23:0] depth_q, depth_d, height_q, height_d;
  logic signed [23:0] top_q, top_d;
  logic [7:0]  alpha_q, alpha_d, r_q, r_d, g_q, g_d, b_q, b_d;
  logic [16:0] bright_q, bright_d, dim_q, dim_d, mult_q, mult_d;
  logic [12:0] texh_q, texh_d;
  logic [CNT_W-1:0] n_q, n_d, w_q, w_d;
  logic [24:0] prod_q, prod_d;
  logic signed [25:0] clip_q, clip_d, split_q, split_d;
  logic signed [25:0] dtop_q, dtop_d, dbot_q, dbot_d, s1b_q, s1b_d, s2t_q, s2t_d;
  logic seg2_q, seg2_d, sel_q, sel_d;
  logic [19:0] srcy_q, srcy_d, srch_q, srch_d;
  logic [RAY_COLUMNS-1:0] valid_q, valid_d;

  logic [RAY_AW-1:0] cnt_raddr;
  logic [CNT_W-1:0]  cnt_rdata, cnt_wdata, cnt_cur;
  logic              cnt_we;
  logic              hit_we;
  logic [RAY_AW+HIT_AW-1:0] hit_waddr, hit_raddr;
  logic [ENTRY_W-1:0] hit_wdata, hit_rdata;
  logic [23:0]        h_dist;
  logic signed [23:0] h_top;
  logic [7:0]         h_alpha;
  logic               h_near;

  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_num;
  logic [QUOT_W-1:0]     div_quot;

  logic signed [25:0] seg_t, seg_b, diff;
  logic [37:0] scale_prod;
  logic [40:0] recip;
  logic [17:0] q0;
  logic [25:0] q0x255;
  logic [33:0] dim_prod;
  logic [16:0] factor;
  logic [24:0] pr, pg, pb;

  scp_ram #(.WIDTH(CNT_W), .DEPTH(RAY_COLUMNS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (ray_q),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  scp_ram #(.WIDTH(ENTRY_W), .DEPTH(RAY_COLUMNS * MAX_HITS)) u_hit_ram (
    .clk_i   (clk_i),
    .we_i    (hit_we),
    .waddr_i (hit_waddr),
    .wdata_i (hit_wdata),
    .raddr_i (hit_raddr),
    .rdata_o (hit_rdata)
  );

  scp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (height_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign cnt_cur = valid_q[ray_q] ? cnt_rdata : '0;
  assign h_dist  = hit_rdata[23:0];
  assign h_top   = $signed(hit_rdata[47:24]);
  assign h_alpha = hit_rdata[55:48];
  assign h_near  = h_dist < depth_q;

  assign seg_t = sel_q ? s2t_q : dtop_q;
  assign seg_b = sel_q ? dbot_q : s1b_q;

  assign recip    = {16'b0, prod_q} * 41'h8081;
  assign q0       = recip[40:23];
  assign q0x255   = {q0, 8'b0} - {8'b0, q0};
  assign dim_prod = bright_q * mult_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(s_axis_tuser))
            CMD_CLEAR:  state_d = ST_IDLE;
            CMD_RECORD: state_d = ST_CNT;
            CMD_QUERY:  state_d = ST_CNT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT: begin
        if (!inrange_q || cmd_q == CMD_RECORD) begin
          state_d = ST_IDLE;
        end else if (cnt_cur == '0) begin
          state_d = ST_DIM;
        end else begin
          state_d = ST_HIT;
        end
      end
      ST_HIT: begin
        if (h_near && h_alpha != ALPHA_OPAQUE) begin
          state_d = ST_SCALE;
        end else if (w_q + CNT_W'(1) < n_q) begin
          state_d = ST_HIT;
        end else begin
          state_d = ST_DIM;
        end
      end
      ST_SCALE: state_d = (w_q + CNT_W'(1) < n_q) ? ST_HIT : ST_DIM;
      ST_DIM:   state_d = ST_SEG;
      ST_SEG:   state_d = (dtop_q < dbot_q) ? ST_Y : ST_IDLE;
      ST_Y:     state_d = (diff > 26'sd0) ? ST_Y_WAIT : ST_H;
      ST_Y_WAIT: state_d = div_done ? ST_H : ST_Y_WAIT;
      ST_H:     state_d = ST_H_WAIT;
      ST_H_WAIT: state_d = div_done ? ST_SEND : ST_H_WAIT;
      ST_SEND: begin
        if (m_axis_tready) begin
          state_d = (!sel_q && seg2_q) ? ST_Y : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d = cmd_q;       inrange_d = inrange_q; ray_d = ray_q;
    depth_d = depth_q;   top_d = top_q;         alpha_d = alpha_q;
    height_d = height_q; bright_d = bright_q;   texh_d = texh_q;
    r_d = r_q; g_d = g_q; b_d = b_q;
    n_d = n_q; w_d = w_q; prod_d = prod_q; mult_d = mult_q; dim_d = dim_q;
    clip_d = clip_q; split_d = split_q;
    dtop_d = dtop_q; dbot_d = dbot_q; s1b_d = s1b_q; s2t_d = s2t_q;
    seg2_d = seg2_q; sel_d = sel_q;
    srcy_d = srcy_q; srch_d = srch_q;
    valid_d = valid_q;
    cnt_raddr = ray_q;
    cnt_we = 1'b0;
    cnt_wdata = '0;
    hit_we = 1'b0;
    hit_waddr = {ray_q, cnt_cur[HIT_AW-1:0]};
    hit_wdata = {alpha_q, top_q, depth_q};
    div_start = 1'b0;
    diff = 26'sd0;
    case (state_q)
      ST_Y:    diff = seg_t - {{2{top_q[23]}}, top_q};
      default: diff = seg_b - seg_t;
    endcase
    scale_prod = diff[24:0] * texh_q;
    div_num = {scale_prod, 8'b0};

    case (state_q)
      ST_IDLE: begin
        w_d = '0;
        mult_d = UNITY;
        clip_d = LINE_INIT;
        split_d = LINE_INIT;
        if (accept) begin
          cmd_d = cmd_e'(s_axis_tuser);
          depth_d = in_depth;   top_d = $signed(in_top); alpha_d = in_alpha;
          height_d = in_height; texh_d = in_texh;
          r_d = in_r; g_d = in_g; b_d = in_b;
          bright_d = (in_bright > UNITY) ? UNITY : in_bright;
          if (cmd_e'(s_axis_tuser) == CMD_QUERY) begin
            inrange_d = (32'(in_column) < SCREEN_COLUMNS) && (height_d != '0);
            ray_d = (32'(ray_full) >= RAY_COLUMNS) ? RAY_AW'(RAY_COLUMNS - 1)
                                                   : ray_full[RAY_AW-1:0];
          end else begin
            inrange_d = 32'(in_column) < RAY_COLUMNS;
            ray_d = in_column[RAY_AW-1:0];
          end
          cnt_raddr = ray_d;
          if (cmd_e'(s_axis_tuser) == CMD_CLEAR && inrange_d) begin
            valid_d[ray_d] = 1'b0;
          end
        end
      end
      ST_CNT: begin
        n_d = cnt_cur;
        if (inrange_q && cmd_q == CMD_RECORD && 32'(cnt_cur) < MAX_HITS) begin
          hit_we = 1'b1;
          cnt_we = 1'b1;
          cnt_wdata = cnt_cur + CNT_W'(1);
          valid_d[ray_q] = 1'b1;
        end
      end
      ST_HIT: begin
        if (h_near) begin
          if (h_alpha == ALPHA_OPAQUE) begin
            if ($signed({{2{h_top[23]}}, h_top}) < clip_q) clip_d = {{2{h_top[23]}}, h_top};
          end else begin
            if ($signed({{2{h_top[23]}}, h_top}) < split_q) split_d = {{2{h_top[23]}}, h_top};
            prod_d = mult_q * (8'd255 - h_alpha);
          end
        end
        if (!(h_near && h_alpha != ALPHA_OPAQUE)) w_d = w_q + CNT_W'(1);
      end
      ST_SCALE: begin
        mult_d = (q0x255 > {1'b0, prod_q}) ? 17'(q0 - 18'd1) : q0[16:0];
        w_d = w_q + CNT_W'(1);
      end
      ST_DIM: begin
        dim_d = dim_prod[32:16];
        dtop_d = {{2{top_q[23]}}, top_q};
        dbot_d = {{2{top_q[23]}}, top_q} + $signed({2'b00, height_q});
        if (dbot_d > clip_q) dbot_d = clip_q;
      end
      ST_SEG: begin
        s1b_d = (split_q < dbot_q) ? split_q : dbot_q;
        s2t_d = (split_q > dtop_q) ? split_q : dtop_q;
        seg2_d = s2t_d < dbot_q;
        sel_d = dtop_q >= s1b_d;
      end
      ST_Y: begin
        srcy_d = '0;
        div_start = diff > 26'sd0;
      end
      ST_Y_WAIT: if (div_done) srcy_d = div_quot;
      ST_H: div_start = 1'b1;
      ST_H_WAIT: if (div_done) srch_d = div_quot;
      ST_SEND: if (m_axis_tready) sel_d = 1'b1;
      default: ;
    endcase
    hit_raddr = {ray_q, w_d[HIT_AW-1:0]};
  end

  assign factor = sel_q ? dim_q : bright_q;
  assign pr = r_q * factor;
  assign pg = g_q * factor;
  assign pb = b_q * factor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;       inrange_q <= inrange_d; ray_q <= ray_d;
    depth_q <= depth_d;   top_q <= top_d;         alpha_q <= alpha_d;
    height_q <= height_d; bright_q <= bright_d;   texh_q <= texh_d;
    r_q <= r_d; g_q <= g_d; b_q <= b_d;
    n_q <= n_d; w_q <= w_d; prod_q <= prod_d; mult_q <= mult_d; dim_q <= dim_d;
    clip_q <= clip_d; split_q <= split_d;
    dtop_q <= dtop_d; dbot_q <= dbot_d; s1b_q <= s1b_d; s2t_q <= s2t_d;
    seg2_q <= seg2_d; sel_q <= sel_d;
    srcy_q <= srcy_d; srch_q <= srch_d;
  end

  assign m_axis_tvalid = (state_q == ST_SEND);
  assign m_axis_tlast  = sel_q || !seg2_q;
  assign m_axis_tdata  = {8'b0, pb[23:16], pg[23:16], pr[23:16], srch_q, srcy_q,
                          seg_b[23:0], seg_t[23:0]};

endmodule
